// File: hdl/hbm_pkg.sv
package hbm_pkg;

  localparam int MAX_CANDIDATES = 64;
  localparam int RUN_W          = $clog2(MAX_CANDIDATES + 1);

  localparam int WORD_W     = 64;
  localparam int NUM_WORDS  = 4;
  localparam int CNT_W      = 7;
  localparam int DIST_W     = 9;
  localparam int MAP_W      = 20;
  localparam int POS_W      = 6;
  localparam int CFG_W      = 9;
  localparam int PROD_W     = 2 * DIST_W;

  localparam int IN_DATA_W  = 536;
  localparam int OUT_DATA_W = 48;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [CFG_W-1:0] BOUND_RESET = 9'd75;
  localparam logic [CFG_W-1:0] RATIO_RESET = 9'd179;

  localparam logic [31:0] MASK_1 = 32'h5555_5555;
  localparam logic [31:0] MASK_2 = 32'h3333_3333;
  localparam logic [31:0] MASK_4 = 32'h0F0F_0F0F;

  typedef enum logic [0:0] {
    REG_INITIAL_BOUND = 1'b0,
    REG_RATIO_Q8      = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [MAP_W-1:0]  map;
    logic              last;
  } hbm_item_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  pos;
    logic [MAP_W-1:0]  map;
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] second;
  } hbm_run_t;

  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = v - ((v >> 1) & MASK_1);
    b = (a & MASK_2) + ((a >> 2) & MASK_2);
    c = (b + (b >> 4)) & MASK_4;
    return 6'(c[7:0]) + 6'(c[15:8]) + 6'(c[23:16]) + 6'(c[31:24]);
  endfunction

  function automatic logic [CNT_W-1:0] pop64(input logic [WORD_W-1:0] v);
    return CNT_W'(pop32(v[31:0])) + CNT_W'(pop32(v[63:32]));
  endfunction

endpackage

// File: hdl/hamming_best_two_ratio_match.sv
// Hamming best-two ratio matcher.
// Slave stream: one request per candidate. s_axis_tdata carries the query
// descriptor, the candidate descriptor and the candidate's map index;
// s_axis_tlast marks the final candidate of a query's run.
// Master stream: one result per run, sent after the request with tlast:
// matched flag, best position, best map index, best and second distances.
// Config port: cfg_we with cfg_index 0 writes initial_bound, 1 writes
// ratio_q8; write only while the block is idle.
// Throughput: one candidate per cycle when not held by back-pressure, set by the
// two-stage popcount pipeline feeding a 4-entry queue and the best/second update
// in the back end. The last request passes the stage-1 and stage-2 registers, the
// queue, the run summary register and the output register before m_axis_tvalid.
// Reset clears all valids, the queue and the run position and loads the
// register defaults (bound 75, ratio 179). When m_axis_tready is low the
// result holds; candidates keep flowing and only a later run's end waits.
module hamming_best_two_ratio_match (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // query_word0..3, cand_word0..3, cand_map_index, zero fill
  input  logic [hbm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // matched, best_position, best_map_index, best_distance, second_distance, zero fill
  output logic [hbm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [hbm_pkg::CFG_W-1:0]      cfg_data
);
  import hbm_pkg::*;

  logic [CFG_W-1:0]      initial_bound;
  logic [CFG_W-1:0]      ratio_q8;

  logic                  f_valid;
  logic                  f_ready;
  hbm_item_t             f_item;
  logic                  q_valid;
  logic                  q_ready;
  hbm_item_t             q_item;
  logic [FIFO_CNT_W-1:0] q_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_bound <= BOUND_RESET;
      ratio_q8      <= RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_INITIAL_BOUND: initial_bound <= cfg_data;
        REG_RATIO_Q8:      ratio_q8      <= cfg_data;
        default:           ratio_q8      <= ratio_q8;
      endcase
    end
  end

  hbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  hbm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item),
    .level     (q_level)
  );

  hbm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (q_valid),
    .item_ready    (q_ready),
    .item          (q_item),
    .initial_bound (initial_bound),
    .ratio_q8      (ratio_q8),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_data      (m_axis_tdata)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("candidate queue overflow");

  a_match_nonzero_second: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[44:36] != '0))
    else $error("match reported with zero second distance");

endmodule

// File: hdl/hbm_front.sv
module hbm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hbm_pkg::IN_DATA_W-1:0] in_data,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hbm_pkg::hbm_item_t            out_item
);
  import hbm_pkg::*;

  logic             s1_valid;
  logic [CNT_W-1:0] s1_cnt [NUM_WORDS];
  logic [MAP_W-1:0] s1_map;
  logic             s1_last;
  logic             s1_ready;

  logic             s2_valid;
  hbm_item_t        s2_item;
  logic             s2_ready;

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // stage 1: per-word popcount of query xor candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        s1_cnt[w] <= pop64(in_data[w*WORD_W +: WORD_W] ^
                           in_data[(NUM_WORDS+w)*WORD_W +: WORD_W]);
      end
      s1_map  <= in_data[2*NUM_WORDS*WORD_W +: MAP_W];
      s1_last <= in_last;
    end
  end

  // stage 2: total distance
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_item.distance <= DIST_W'(s1_cnt[0]) + DIST_W'(s1_cnt[1]) +
                          DIST_W'(s1_cnt[2]) + DIST_W'(s1_cnt[3]);
      s2_item.map      <= s1_map;
      s2_item.last     <= s1_last;
    end
  end

  assign out_valid = s2_valid;
  assign out_item  = s2_item;

endmodule

// File: hdl/hbm_fifo.sv
module hbm_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hbm_pkg::hbm_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hbm_pkg::hbm_item_t             out_item,
  output logic [hbm_pkg::FIFO_CNT_W-1:0] level
);
  import hbm_pkg::*;

  hbm_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  push;
  logic                  pop;

  assign in_ready  = count != FIFO_CNT_W'(FIFO_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rptr];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

endmodule

// File: hdl/hbm_back.sv
module hbm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  hbm_pkg::hbm_item_t             item,
  input  logic [hbm_pkg::CFG_W-1:0]      initial_bound,
  input  logic [hbm_pkg::CFG_W-1:0]      ratio_q8,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hbm_pkg::OUT_DATA_W-1:0] out_data
);
  import hbm_pkg::*;

  logic [DIST_W-1:0] best;
  logic [DIST_W-1:0] second;
  logic [POS_W-1:0]  bpos;
  logic [MAP_W-1:0]  bmap;
  logic              found;
  logic [RUN_W-1:0]  run_pos;

  logic [DIST_W-1:0] base_best;
  logic [DIST_W-1:0] base_second;
  logic [POS_W-1:0]  base_pos;
  logic [MAP_W-1:0]  base_map;
  logic              base_found;
  hbm_run_t          upd;

  logic              r_valid;
  hbm_run_t          r;
  logic              r_move;
  logic              o_valid;
  logic [OUT_DATA_W-1:0] o_data;
  logic [PROD_W-1:0] prod;
  logic              matched;
  logic              take;

  assign r_move     = r_valid && (!o_valid || out_ready);
  assign item_ready = !item.last || !r_valid || r_move;
  assign take       = item_valid && item_ready;

  // a new run starts from the current bound
  always_comb begin
    if (run_pos == '0) begin
      base_best   = initial_bound;
      base_second = initial_bound;
      base_pos    = '0;
      base_map    = '0;
      base_found  = 1'b0;
    end else begin
      base_best   = best;
      base_second = second;
      base_pos    = bpos;
      base_map    = bmap;
      base_found  = found;
    end
    upd.best   = base_best;
    upd.second = base_second;
    upd.pos    = base_pos;
    upd.map    = base_map;
    upd.found  = base_found;
    if (run_pos < RUN_W'(MAX_CANDIDATES)) begin
      if (item.distance < base_best) begin
        upd.second = base_best;
        upd.best   = item.distance;
        upd.pos    = POS_W'(run_pos);
        upd.map    = item.map;
        upd.found  = 1'b1;
      end else if (item.distance < base_second) begin
        upd.second = item.distance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_pos <= '0;
    end else if (take) begin
      if (item.last) begin
        run_pos <= '0;
      end else if (run_pos < RUN_W'(MAX_CANDIDATES)) begin
        run_pos <= run_pos + 1'b1;
      end
    end
    if (take) begin
      best   <= upd.best;
      second <= upd.second;
      bpos   <= upd.pos;
      bmap   <= upd.map;
      found  <= upd.found;
    end
  end

  // run summary waits here for the ratio test
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (take && item.last) begin
      r_valid <= 1'b1;
    end else if (r_move) begin
      r_valid <= 1'b0;
    end
    if (take && item.last) begin
      r <= upd;
    end
  end

  assign prod    = PROD_W'(r.second) * PROD_W'(ratio_q8);
  assign matched = r.found && (PROD_W'({r.best, 8'd0}) < prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (r_move) begin
      o_valid <= 1'b1;
    end else if (out_ready) begin
      o_valid <= 1'b0;
    end
    if (r_move) begin
      o_data <= {3'b000, r.second, r.best, r.map, r.pos, matched};
    end
  end

  assign out_valid = o_valid;
  assign out_data  = o_data;

endmodule
